@@ hdl/trd_pkg.sv @@
// Package for the touch release debounce block: request and result types,
// edge FIFO entry type, request and register codes, reset values.
// No dependencies.
package trd_pkg;

  localparam int EDGE_DEPTH_DEF = 8;

  localparam logic [11:0] MAX_X_RST     = 12'd319;
  localparam logic [11:0] MAX_Y_RST     = 12'd239;
  localparam logic [3:0]  REL_SAMP_RST  = 4'd3;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] CFG_MAX_X    = 2'd0;
  localparam logic [1:0] CFG_MAX_Y    = 2'd1;
  localparam logic [1:0] CFG_REL_SAMP = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        read_ok;
    logic        touch_down;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [31:0] now_ms;
    logic [31:0] window_ms;
  } trd_req_t;

  typedef struct packed {
    logic        snap_pressed;
    logic [11:0] snap_x;
    logic [11:0] snap_y;
    logic [31:0] snap_seq;
    logic [31:0] snap_time;
    logic        edge_valid;
    logic        edge_is_down;
    logic [11:0] edge_x;
    logic [11:0] edge_y;
    logic [31:0] edge_time;
    logic [31:0] edge_seq;
    logic        recently_active;
  } trd_rsp_t;

  typedef struct packed {
    logic        down;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] tstamp;
    logic [31:0] seq;
  } trd_edge_t;

  typedef struct packed {
    logic push;
    logic pop;
  } trd_fifo_cmd_t;

endpackage

@@ hdl/trd_stream_if.sv @@
// Valid/ready channel carrying one payload per transfer.
// Payload type is given by the instance; no other dependencies.
interface trd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/trd_edge_fifo.sv @@
// Edge FIFO: circular store with push, pop and the full-store coalesce scan.
// Depends on trd_pkg.
module trd_edge_fifo #(
  parameter int EDGE_DEPTH = trd_pkg::EDGE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  trd_pkg::trd_fifo_cmd_t          cmd_i,
  input  trd_pkg::trd_edge_t              word_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [$clog2(EDGE_DEPTH+1)-1:0] count_o,
  output trd_pkg::trd_edge_t              rdata_o
);

  localparam int AW  = $clog2(EDGE_DEPTH);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(EDGE_DEPTH + 1);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_POP  = 3'd1;
  localparam logic [2:0] F_SCAN = 3'd2;
  localparam logic [2:0] F_KEEP = 3'd3;
  localparam logic [2:0] F_NEW  = 3'd4;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= AW1'(EDGE_DEPTH)) begin
      s = s - AW1'(EDGE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  trd_pkg::trd_edge_t mem_q [EDGE_DEPTH];
  trd_pkg::trd_edge_t rdata_q;
  trd_pkg::trd_edge_t new_q, new_d;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] off_q, off_d;
  logic          done_q, done_d;
  logic          hit_q, hit_d;

  logic               we, rd_en;
  logic [AW-1:0]      wa, ra;
  trd_pkg::trd_edge_t wd;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    off_d   = off_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    new_d   = new_q;
    we      = 1'b0;
    wa      = '0;
    wd      = new_q;
    rd_en   = 1'b0;
    ra      = head_q;
    case (state_q)
      F_IDLE: begin
        if (cmd_i.push) begin
          new_d = word_i;
          wd    = word_i;
          if (count_q < CW'(EDGE_DEPTH)) begin
            we      = 1'b1;
            wa      = slot(head_q, count_q[AW-1:0]);
            count_d = count_q + CW'(1);
            done_d  = 1'b1;
          end else if (word_i.down) begin
            we      = 1'b1;
            head_d  = '0;
            count_d = CW'(1);
            done_d  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            ra      = slot(head_q, AW'(EDGE_DEPTH - 1));
            off_d   = AW'(EDGE_DEPTH - 1);
            state_d = F_SCAN;
          end
        end else if (cmd_i.pop) begin
          if (count_q != '0) begin
            rd_en   = 1'b1;
            head_d  = slot(head_q, AW'(1));
            count_d = count_q - CW'(1);
            hit_d   = 1'b1;
            state_d = F_POP;
          end else begin
            hit_d  = 1'b0;
            done_d = 1'b1;
          end
        end
      end
      F_POP: begin
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      F_SCAN: begin
        if (rdata_q.down) begin
          state_d = F_KEEP;
        end else if (off_q == '0) begin
          we      = 1'b1;
          head_d  = '0;
          count_d = CW'(1);
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          rd_en = 1'b1;
          ra    = slot(head_q, off_q - AW'(1));
          off_d = off_q - AW'(1);
        end
      end
      F_KEEP: begin
        we      = 1'b1;
        wd      = rdata_q;
        state_d = F_NEW;
      end
      F_NEW: begin
        we      = 1'b1;
        wa      = AW'(1);
        head_d  = '0;
        count_d = CW'(2);
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[ra];
    end
  end

  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule

@@ hdl/touch_release_debounce_edge_fifo.sv @@
// Touch release debounce with edge FIFO: top level, sequencer and snapshot.
// Depends on trd_pkg, trd_stream_if and trd_edge_fifo.
//
//  channel  dir  payload    transfer when
//  in_s     in   trd_req_t  in_s.valid && in_s.ready
//  out_s    out  trd_rsp_t  out_s.valid && out_s.ready
//  cfg      in   idx/data   cfg_we_i
//
// One request at a time: a sample that stores an edge and a pop wait for the
// edge FIFO, and a release into a full FIFO first scans it backward, one FIFO
// read per cycle. Result is held in an output register, so input is taken
// again while the last result waits; the next result stalls until it is free.
// Reset is asynchronous; FIFO entries are only read below the fill count.
module touch_release_debounce_edge_fifo #(
  parameter int EDGE_DEPTH = trd_pkg::EDGE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [11:0]  cfg_wdata_i,
  trd_stream_if.sink   in_s,
  trd_stream_if.source out_s
);

  localparam int CW = $clog2(EDGE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  logic [11:0] max_x_q, max_y_q;
  logic [3:0]  rel_samp_q;

  trd_pkg::trd_req_t req_q;

  logic        stable_q;
  logic [3:0]  run_q;
  logic        cur_pressed_q;
  logic [11:0] cur_x_q, cur_y_q;
  logic [31:0] cur_seq_q, cur_time_q, act_time_q;
  logic        act_seen_q;

  logic               ev_q, ra_q;
  trd_pkg::trd_edge_t edge_q;

  trd_pkg::trd_rsp_t out_q, rsp;
  logic              out_valid_q;

  trd_pkg::trd_fifo_cmd_t fifo_cmd;
  trd_pkg::trd_edge_t     fifo_word, fifo_rdata;
  logic                   fifo_done, fifo_hit;
  logic [CW-1:0]          fifo_count;

  // sample and query evaluation
  logic        sample, confirm, publish, edge_ev, moved, act_upd, query_hit;
  logic [3:0]  run_inc;
  logic [11:0] nx, ny, new_x, new_y;
  logic [31:0] seq_inc, new_seq, age;
  logic        load_out;

  always_comb begin
    sample  = (req_q.req_type == trd_pkg::REQ_SAMPLE) && req_q.read_ok;
    run_inc = (run_q < rel_samp_q) ? run_q + 4'd1 : run_q;
    confirm = stable_q && !req_q.touch_down && (run_inc >= rel_samp_q);
    publish = sample && (req_q.touch_down || confirm);
    edge_ev = sample && (req_q.touch_down ? !stable_q : confirm);
    nx = (req_q.raw_x > {4'd0, max_x_q}) ? max_x_q : req_q.raw_x[11:0];
    ny = (req_q.raw_y > {4'd0, max_y_q}) ? max_y_q : req_q.raw_y[11:0];
    moved   = req_q.touch_down && ((nx != cur_x_q) || (ny != cur_y_q));
    seq_inc = cur_seq_q + 32'd1;
    if (seq_inc == 32'd0) begin
      seq_inc = 32'd1;
    end
    new_seq = (edge_ev || moved) ? seq_inc : cur_seq_q;
    new_x   = req_q.touch_down ? nx : cur_x_q;
    new_y   = req_q.touch_down ? ny : cur_y_q;
    act_upd = req_q.touch_down || cur_pressed_q;
    age       = req_q.now_ms - act_time_q;
    query_hit = cur_pressed_q || (act_seen_q && (age <= req_q.window_ms));
  end

  always_comb begin
    fifo_cmd.push    = (state_q == S_EXEC) && edge_ev;
    fifo_cmd.pop     = (state_q == S_EXEC) && (req_q.req_type == trd_pkg::REQ_POP);
    fifo_word.down   = req_q.touch_down;
    fifo_word.x      = new_x;
    fifo_word.y      = new_y;
    fifo_word.tstamp = req_q.now_ms;
    fifo_word.seq    = new_seq;
  end

  trd_edge_fifo #(
    .EDGE_DEPTH (EDGE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (fifo_cmd),
    .word_i  (fifo_word),
    .done_o  (fifo_done),
    .hit_o   (fifo_hit),
    .count_o (fifo_count),
    .rdata_o (fifo_rdata)
  );

  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_s.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_s.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fifo_cmd.push || fifo_cmd.pop) begin
          state_d = S_WAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WAIT: begin
        if (fifo_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.snap_pressed    = cur_pressed_q;
    rsp.snap_x          = cur_x_q;
    rsp.snap_y          = cur_y_q;
    rsp.snap_seq        = cur_seq_q;
    rsp.snap_time       = cur_time_q;
    rsp.edge_valid      = ev_q;
    rsp.edge_is_down    = ev_q & edge_q.down;
    rsp.edge_x          = ev_q ? edge_q.x : 12'd0;
    rsp.edge_y          = ev_q ? edge_q.y : 12'd0;
    rsp.edge_time       = ev_q ? edge_q.tstamp : 32'd0;
    rsp.edge_seq        = ev_q ? edge_q.seq : 32'd0;
    rsp.recently_active = ra_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      max_x_q       <= trd_pkg::MAX_X_RST;
      max_y_q       <= trd_pkg::MAX_Y_RST;
      rel_samp_q    <= trd_pkg::REL_SAMP_RST;
      stable_q      <= 1'b0;
      run_q         <= 4'd0;
      cur_pressed_q <= 1'b0;
      cur_x_q       <= 12'd0;
      cur_y_q       <= 12'd0;
      cur_seq_q     <= 32'd0;
      cur_time_q    <= 32'd0;
      act_time_q    <= 32'd0;
      act_seen_q    <= 1'b0;
      ev_q          <= 1'b0;
      ra_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          trd_pkg::CFG_MAX_X:    max_x_q    <= cfg_wdata_i;
          trd_pkg::CFG_MAX_Y:    max_y_q    <= cfg_wdata_i;
          trd_pkg::CFG_REL_SAMP: rel_samp_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (state_q == S_EXEC) begin
        ev_q <= 1'b0;
        ra_q <= (req_q.req_type == trd_pkg::REQ_QUERY) && query_hit;
        if (sample) begin
          if (req_q.touch_down) begin
            stable_q <= 1'b1;
            run_q    <= 4'd0;
          end else if (stable_q) begin
            stable_q <= !confirm;
            run_q    <= confirm ? 4'd0 : run_inc;
          end else begin
            run_q <= 4'd0;
          end
        end
        if (publish) begin
          cur_pressed_q <= req_q.touch_down;
          cur_x_q       <= new_x;
          cur_y_q       <= new_y;
          cur_seq_q     <= new_seq;
          cur_time_q    <= req_q.now_ms;
          if (act_upd) begin
            act_time_q <= req_q.now_ms;
            act_seen_q <= 1'b1;
          end
        end
      end
      if ((state_q == S_WAIT) && fifo_done && (req_q.req_type == trd_pkg::REQ_POP)) begin
        ev_q <= fifo_hit;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      req_q <= in_s.data;
    end
    if ((state_q == S_WAIT) && fifo_done) begin
      edge_q <= fifo_rdata;
    end
    if (load_out) begin
      out_q <= rsp;
    end
  end

  assign in_s.ready  = (state_q == S_IDLE);
  assign out_s.valid = out_valid_q;
  assign out_s.data  = out_q;

`ifndef SYNTHESIS
  a_fifo_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CW'(EDGE_DEPTH))
    else $error("edge FIFO count beyond depth");

  a_fifo_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_done |-> (state_q == S_WAIT))
    else $error("FIFO completion outside wait state");

  a_pressed_matches_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pressed_q == stable_q)
    else $error("snapshot pressed state differs from debounced state");

  a_seq_nonzero_when_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pressed_q |-> (cur_seq_q != 32'd0))
    else $error("sequence number zero while pressed");
`endif

endmodule

@@ verif/trd_checker.sv @@
// Checker for the touch release debounce block: watches both channels and the
// register port, predicts each result and compares it field by field.
// Depends on trd_pkg.
module trd_checker
  import trd_pkg::*;
#(
  parameter int EDGE_DEPTH = EDGE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  trd_req_t    req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  trd_rsp_t    rsp_i,
  output int          mismatches_o,
  output int          pending_o
);

  logic [11:0] lim_x, lim_y;
  logic [3:0]  rel_count;

  logic        stable_down;
  logic [3:0]  rel_run;
  logic        cur_pressed;
  logic [11:0] cur_x, cur_y;
  logic [31:0] cur_seq, cur_time, act_time;
  logic        act_seen;

  trd_edge_t   edge_mem [EDGE_DEPTH];
  int unsigned edge_head, edge_fill;

  trd_rsp_t    due_rsp [$];
  int          mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_edge(trd_edge_t e);
    edge_mem[(edge_head + edge_fill) % EDGE_DEPTH] = e;
    edge_fill++;
  endfunction

  // Full queue: start afresh, keeping the newest press ahead of a release.
  function automatic void store_edge(trd_edge_t e);
    trd_edge_t   kept;
    logic        have;
    int unsigned slot;
    have = 1'b0;
    kept = '0;
    if (edge_fill < EDGE_DEPTH) begin
      push_edge(e);
    end else begin
      if (!e.down) begin
        for (int i = EDGE_DEPTH - 1; i >= 0; i--) begin
          slot = (edge_head + i) % EDGE_DEPTH;
          if (!have && edge_mem[slot].down) begin
            kept = edge_mem[slot];
            have = 1'b1;
          end
        end
      end
      edge_head = 0;
      edge_fill = 0;
      if (have)
        push_edge(kept);
      push_edge(e);
    end
  endfunction

  function automatic void publish_sample(logic pressed, logic [15:0] rx, logic [15:0] ry,
                                         logic [31:0] now, logic is_edge);
    logic [11:0] nx, ny;
    logic        moved, was_pressed;
    trd_edge_t   e;
    nx = pressed ? ((rx > 16'(lim_x)) ? lim_x : rx[11:0]) : 12'd0;
    ny = pressed ? ((ry > 16'(lim_y)) ? lim_y : ry[11:0]) : 12'd0;
    was_pressed = cur_pressed;
    moved = pressed && (nx != cur_x || ny != cur_y);
    if (is_edge || moved) begin
      cur_seq = cur_seq + 32'd1;
      if (cur_seq == 32'd0)
        cur_seq = 32'd1;
    end
    cur_pressed = pressed;
    if (pressed) begin
      cur_x = nx;
      cur_y = ny;
    end
    cur_time = now;
    if (pressed || was_pressed != pressed) begin
      act_time = now;
      act_seen = 1'b1;
    end
    if (is_edge) begin
      e.down   = pressed;
      e.x      = cur_x;
      e.y      = cur_y;
      e.tstamp = now;
      e.seq    = cur_seq;
      store_edge(e);
    end
  endfunction

  function automatic trd_rsp_t touch_step(trd_req_t r);
    trd_rsp_t  o;
    trd_edge_t e;
    logic      was_up;
    o = '0;
    case (r.req_type)
      REQ_SAMPLE: begin
        if (r.read_ok) begin
          if (r.touch_down) begin
            was_up = !stable_down;
            rel_run = 4'd0;
            stable_down = 1'b1;
            publish_sample(1'b1, r.raw_x, r.raw_y, r.now_ms, was_up);
          end else if (stable_down) begin
            if (rel_run < rel_count)
              rel_run = rel_run + 4'd1;
            if (rel_run >= rel_count) begin
              stable_down = 1'b0;
              rel_run = 4'd0;
              publish_sample(1'b0, r.raw_x, r.raw_y, r.now_ms, 1'b1);
            end
          end else begin
            rel_run = 4'd0;
          end
        end
      end
      REQ_POP: begin
        if (edge_fill != 0) begin
          e = edge_mem[edge_head];
          o.edge_valid   = 1'b1;
          o.edge_is_down = e.down;
          o.edge_x       = e.x;
          o.edge_y       = e.y;
          o.edge_time    = e.tstamp;
          o.edge_seq     = e.seq;
          edge_head = (edge_head + 1) % EDGE_DEPTH;
          edge_fill--;
        end
      end
      REQ_QUERY: begin
        if (cur_pressed)
          o.recently_active = 1'b1;
        else if (act_seen)
          o.recently_active = (r.now_ms - act_time) <= r.window_ms;
      end
      default: ;
    endcase
    o.snap_pressed = cur_pressed;
    o.snap_x       = cur_x;
    o.snap_y       = cur_y;
    o.snap_seq     = cur_seq;
    o.snap_time    = cur_time;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trd_rsp_t want;
    if (!rst_ni) begin
      lim_x       = MAX_X_RST;
      lim_y       = MAX_Y_RST;
      rel_count   = REL_SAMP_RST;
      stable_down = 1'b0;
      rel_run     = 4'd0;
      cur_pressed = 1'b0;
      cur_x       = '0;
      cur_y       = '0;
      cur_seq     = '0;
      cur_time    = '0;
      act_time    = '0;
      act_seen    = 1'b0;
      edge_head   = 0;
      edge_fill   = 0;
      due_rsp.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_X:    lim_x = cfg_wdata_i;
          CFG_MAX_Y:    lim_y = cfg_wdata_i;
          CFG_REL_SAMP: rel_count = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (due_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_i);
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          check_field("snap_pressed", 32'(want.snap_pressed), 32'(rsp_i.snap_pressed));
          check_field("snap_x", 32'(want.snap_x), 32'(rsp_i.snap_x));
          check_field("snap_y", 32'(want.snap_y), 32'(rsp_i.snap_y));
          check_field("snap_seq", want.snap_seq, rsp_i.snap_seq);
          check_field("snap_time", want.snap_time, rsp_i.snap_time);
          check_field("edge_valid", 32'(want.edge_valid), 32'(rsp_i.edge_valid));
          check_field("edge_is_down", 32'(want.edge_is_down), 32'(rsp_i.edge_is_down));
          check_field("edge_x", 32'(want.edge_x), 32'(rsp_i.edge_x));
          check_field("edge_y", 32'(want.edge_y), 32'(rsp_i.edge_y));
          check_field("edge_time", want.edge_time, rsp_i.edge_time);
          check_field("edge_seq", want.edge_seq, rsp_i.edge_seq);
          check_field("recently_active", 32'(want.recently_active),
                      32'(rsp_i.recently_active));
        end
      end
      if (req_valid_i && req_ready_i)
        due_rsp.push_back(touch_step(req_i));
      pending_o <= due_rsp.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the touch release debounce block: clock, reset, register
// writes and request stimulus, with trd_checker alongside the block.
// Depends on trd_pkg, trd_stream_if, trd_checker and the block itself.
module tb;
  import trd_pkg::*;

  localparam int         DEPTH         = EDGE_DEPTH_DEF;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 2 * DEPTH + 10;
  localparam int         PHASE_ITEMS   = 305;
  localparam int         PHASES        = 6;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [11:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  trd_req_t    req_data  = '0;
  logic        rsp_ready = 1'b0;

  int          mismatches, pending;
  int          stall_cycles = 0;
  int          n_req = 0;
  int          n_rsp = 0;

  int          tx_idle_pct = 35;
  int          rx_idle_pct = 81;
  int          pop_pct     = 10;
  logic        finger      = 1'b0;
  logic [15:0] pos_x       = '0;
  logic [15:0] pos_y       = '0;
  logic [31:0] clock_ms    = 32'hFFFF_FFC0;
  logic [11:0] cur_max_x   = MAX_X_RST;
  logic [11:0] cur_max_y   = MAX_Y_RST;

  trd_stream_if #(.data_t(trd_req_t)) req_ch ();
  trd_stream_if #(.data_t(trd_rsp_t)) rsp_ch ();

  assign req_ch.valid = req_valid;
  assign req_ch.data  = req_data;
  assign rsp_ch.ready = rsp_ready;

  always #5 clk = ~clk;

  touch_release_debounce_edge_fifo #(.EDGE_DEPTH(DEPTH)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_s       (req_ch),
    .out_s      (rsp_ch)
  );

  trd_checker #(.EDGE_DEPTH(DEPTH)) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_i       (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_i       (rsp_ch.data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (req_ch.valid && req_ch.ready)
      n_req <= n_req + 1;
    if (rsp_ch.valid && rsp_ch.ready)
      n_rsp <= n_rsp + 1;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  function automatic trd_req_t make_req(logic [1:0] kind, logic ok, logic down,
                                        logic [15:0] x, logic [15:0] y,
                                        logic [31:0] now, logic [31:0] win);
    trd_req_t r;
    r.req_type   = kind;
    r.read_ok    = ok;
    r.touch_down = down;
    r.raw_x      = x;
    r.raw_y      = y;
    r.now_ms     = now;
    r.window_ms  = win;
    return r;
  endfunction

  function automatic logic [15:0] wander(logic [15:0] p, logic [11:0] lim);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40)
      return p;
    if (roll < 70)
      return p + 16'($urandom_range(6)) - 16'd3;
    if (roll < 88)
      return 16'($urandom_range(32'(lim) + 16));
    return 16'($urandom());
  endfunction

  task automatic send_req(input trd_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [11:0] x, input logic [11:0] y, input logic [3:0] rs);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_MAX_X, x);
    write_reg(CFG_MAX_Y, y);
    write_reg(CFG_REL_SAMP, {8'd0, rs});
    cfg_we    <= 1'b0;
    cur_max_x = x;
    cur_max_y = y;
  endtask

  task automatic d_sample(input logic ok, input logic down,
                          input logic [15:0] x, input logic [15:0] y);
    clock_ms = clock_ms + 32'd5;
    send_req(make_req(REQ_SAMPLE, ok, down, x, y, clock_ms, $urandom()));
  endtask

  task automatic d_query(input logic [31:0] now, input logic [31:0] win);
    send_req(make_req(REQ_QUERY, 1'b1, 1'b0, 16'($urandom()), 16'($urandom()), now, win));
  endtask

  task automatic d_pop();
    send_req(make_req(REQ_POP, 1'($urandom()), 1'($urandom()), 16'($urandom()),
                      16'($urandom()), $urandom(), $urandom()));
  endtask

  task automatic random_req(output trd_req_t r);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)
      clock_ms = $urandom();
    else
      clock_ms = clock_ms + $urandom_range(40);
    r.now_ms = clock_ms;
    case ($urandom_range(4))
      0:       r.window_ms = '0;
      1:       r.window_ms = $urandom_range(60);
      2:       r.window_ms = $urandom_range(2000);
      3:       r.window_ms = $urandom();
      default: r.window_ms = '1;
    endcase
    r.read_ok    = 1'($urandom_range(1));
    r.touch_down = 1'($urandom_range(1));
    r.raw_x      = 16'($urandom());
    r.raw_y      = 16'($urandom());
    roll = $urandom_range(99);
    if (roll < pop_pct) begin
      r.req_type = REQ_POP;
    end else if (roll < pop_pct + 10) begin
      r.req_type = REQ_QUERY;
    end else if (roll < pop_pct + 13) begin
      r.req_type = REQ_UNUSED;
    end else begin
      r.req_type = REQ_SAMPLE;
      r.read_ok  = ($urandom_range(99) >= 8);
      if ($urandom_range(99) < 9)
        finger = ~finger;
      r.touch_down = ($urandom_range(99) < 12) ? ~finger : finger;
      pos_x   = wander(pos_x, cur_max_x);
      pos_y   = wander(pos_y, cur_max_y);
      r.raw_x = pos_x;
      r.raw_y = pos_y;
    end
  endtask

  initial begin
    trd_req_t    r;
    logic [11:0] lx, ly;
    logic [3:0]  rs;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset register values, time stamps close to wrapping
    d_query(clock_ms, '1);
    d_pop();
    send_req(make_req(REQ_UNUSED, 1'b1, 1'b1, 16'd50, 16'd50, clock_ms, '0));
    d_sample(1'b0, 1'b1, 16'd100, 16'd100);
    d_sample(1'b1, 1'b1, 16'd0, 16'd0);
    d_sample(1'b1, 1'b1, '1, '1);
    d_sample(1'b1, 1'b1, '1, '1);
    d_query(clock_ms, '0);
    d_sample(1'b1, 1'b0, 16'd0, 16'd0);
    d_sample(1'b0, 1'b0, 16'd0, 16'd0);
    d_sample(1'b1, 1'b0, 16'd0, 16'd0);
    d_sample(1'b1, 1'b1, 16'd320, 16'd240);
    repeat (3) d_sample(1'b1, 1'b0, 16'd9, 16'd9);
    d_query(clock_ms, '0);
    d_query(clock_ms + 32'd7, 32'd6);
    d_query(clock_ms + 32'd7, 32'd7);
    d_query(clock_ms - 32'd1, 32'hFFFF_FFFE);
    repeat (3) d_pop();

    // zero release count confirms on the first empty sample
    set_config(12'd0, 12'hFFF, 4'd0);
    d_sample(1'b1, 1'b1, 16'd5000, 16'd5000);
    d_sample(1'b1, 1'b0, 16'd7, 16'd7);

    for (int ph = 0; ph < PHASES; ph++) begin
      lx = 12'($urandom_range(4095));
      ly = 12'($urandom_range(4095));
      rs = 4'($urandom_range(15));
      case (ph)
        0: begin set_config(12'hFFF, 12'hFFF, 4'd1); pop_pct = 2;  end
        1: begin set_config(12'd0, 12'd0, 4'd15);    pop_pct = 2;  end
        2: begin set_config(lx, ly, rs);             pop_pct = 25; end
        3: begin set_config(MAX_X_RST, MAX_Y_RST, REL_SAMP_RST); pop_pct = 10; end
        4: begin set_config(lx, ly, rs);             pop_pct = 5;  end
        default: begin set_config(lx, ly, rs);       pop_pct = 15; end
      endcase
      if (ph < 2) begin
        tx_idle_pct = 35;
        rx_idle_pct = 81;
      end else if (ph < 4) begin
        tx_idle_pct = 81;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2)
          drain();
        random_req(r);
        send_req(r);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d results under eight register settings,",
             n_req, n_rsp);
    $display("with full edge queues, release debounce runs and all idling mixes.");
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
